### sv/psrg_pkg.sv
// ----------------------------------------------------------------------------
// psrg_pkg
// Shared types and constants of the periodic stencil row generator.
// ----------------------------------------------------------------------------
package psrg_pkg;

  localparam int IDX_W         = 48;
  localparam int VAL_W         = 32;
  localparam int DIG_W         = 8;
  localparam int GRID_W        = 9;
  localparam int MAX_DIMS_DEF  = 8;
  localparam int MAX_GRID_DEF  = 256;
  localparam int MAX_EDGES_DEF = 32;
  localparam int POT_DEPTH     = 256;

  typedef enum logic [1:0] {
    ACT_GEN  = 2'd0,
    ACT_EDGE = 2'd1,
    ACT_POT  = 2'd2,
    ACT_NONE = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    REG_GRID  = 2'd0,
    REG_DIMS  = 2'd1,
    REG_EDGES = 2'd2,
    REG_FACT  = 2'd3
  } reg_e;

  // table write request
  typedef struct packed {
    logic             edge_we;
    logic             pot_we;
    logic [7:0]       addr;
    logic [2:0]       first;
    logic [2:0]       second;
    logic [VAL_W-1:0] word;
  } tbl_wr_t;

endpackage

### sv/psrg_div.sv
// ----------------------------------------------------------------------------
// psrg_div
// Bit-serial restoring divider: splits one mixed-radix digit off a row index.
// ----------------------------------------------------------------------------
module psrg_div
  import psrg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [IDX_W-1:0]  dividend_i,
  input  logic [GRID_W-1:0] divisor_i,
  output logic              done_o,
  output logic [IDX_W-1:0]  quot_o,
  output logic [GRID_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(IDX_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [IDX_W-1:0]  quot_q, quot_d;
  logic [GRID_W-1:0] rem_q, rem_d;
  logic [GRID_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quot_q[IDX_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      quot_d = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // shift one dividend bit in, subtract when it fits
      rem_d  = fits ? GRID_W'(trial - {1'b0, divisor_i}) : GRID_W'(trial);
      quot_d = {quot_q[IDX_W-2:0], fits};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(IDX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### sv/psrg_tables.sv
// ----------------------------------------------------------------------------
// psrg_tables
// Edge table and potential table, one write and one registered read each.
// ----------------------------------------------------------------------------
module psrg_tables
  import psrg_pkg::*;
#(
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic                                  clk_i,
  input  tbl_wr_t                               wr_i,
  input  logic [(MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1)-1:0] edge_raddr_i,
  input  logic [7:0]                            pot_raddr_i,
  output logic [2:0]                            edge_first_o,
  output logic [2:0]                            edge_second_o,
  output logic [VAL_W-1:0]                      edge_weight_o,
  output logic [VAL_W-1:0]                      pot_o
);

  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  logic [VAL_W+5:0] edge_mem [MAX_EDGES];
  logic [VAL_W-1:0] pot_mem  [POT_DEPTH];
  logic [VAL_W+5:0] edge_rd_q;
  logic [VAL_W-1:0] pot_rd_q;
  logic             edge_in_range;

  assign edge_in_range = {1'b0, wr_i.addr} < 9'(MAX_EDGES);

  always_ff @(posedge clk_i) begin
    if (wr_i.edge_we && edge_in_range) begin
      edge_mem[wr_i.addr[EW-1:0]] <= {wr_i.first, wr_i.second, wr_i.word};
    end
    if (wr_i.pot_we) begin
      pot_mem[wr_i.addr] <= wr_i.word;
    end
    edge_rd_q <= edge_mem[edge_raddr_i];
    pot_rd_q  <= pot_mem[pot_raddr_i];
  end

  assign edge_first_o  = edge_rd_q[VAL_W+5:VAL_W+3];
  assign edge_second_o = edge_rd_q[VAL_W+2:VAL_W];
  assign edge_weight_o = edge_rd_q[VAL_W-1:0];
  assign pot_o         = pot_rd_q;

endmodule

### sv/periodic_stencil_row_generator.sv
// ----------------------------------------------------------------------------
// periodic_stencil_row_generator
// Emits one sparse row of a fourth-order periodic Laplacian plus a pairwise
// potential; load words fill the edge and potential tables.
//
// channel  dir  tdata                                     tuser / tlast
// s_axis   in   row, entry idx, first, second, word       action / -
// m_axis   out  column_index, entry_value                 error_flag / last
// cfg      in   cfg_idx_i selects grid, dims, edges, fact  -
//
// A load word is taken only while idle. A generate word splits its row
// index into nd digits (nd dimensions, ne edges) on the bit-serial divider,
// walks the ne edges through the table read ports and one multiplier, and
// then emits one entry at a time. An error row skips the divider and the edge
// walk. Output stalls hold the sequencer.
// Reset clears control state only; tables hold garbage until written.
// ----------------------------------------------------------------------------
module periodic_stencil_row_generator
  import psrg_pkg::*;
#(
  parameter int MAX_DIMS  = MAX_DIMS_DEF,
  parameter int MAX_GRID  = MAX_GRID_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row_index[47:0], entry_index[55:48], edge_first[58:56],
  // edge_second[61:59], entry_word[93:62], zero fill
  input  logic [95:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // column_index[47:0], entry_value[79:48]
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // error_flag[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW = DW + 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = EW + 1;
  localparam int AW = 56;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b00000000001,
    S_CHECK     = 11'b00000000010,
    S_DIV_START = 11'b00000000100,
    S_DIV_WAIT  = 11'b00000001000,
    S_EDGE_RD   = 11'b00000010000,
    S_EDGE_DA   = 11'b00000100000,
    S_EDGE_DB   = 11'b00001000000,
    S_EDGE_MUL  = 11'b00010000000,
    S_EDGE_ACC  = 11'b00100000000,
    S_EMIT_DIAG = 11'b01000000000,
    S_EMIT_NB   = 11'b10000000000
  } state_e;

  // error row uses the diagonal emit state with err_q set
  state_e state_q, state_d;

  logic [GRID_W-1:0] grid_q;
  logic [3:0]        dims_q;
  logic [5:0]        edges_q;
  logic [VAL_W-1:0]  fact_q;

  logic [GRID_W-1:0] g_eff;
  logic [3:0]        nd_eff;
  logic [ECW-1:0]    ne_c;
  logic [CW-1:0]     nd_c;

  logic [IDX_W-1:0]  row_q, rem_q, total_q;
  logic              big_q, err_q;
  logic [CW-1:0]     dcnt_q;
  logic [ECW-1:0]    ecnt_q;
  logic [1:0]        oi_q;
  logic [DIG_W-1:0]  digit_q  [MAX_DIMS];
  logic [IDX_W-1:0]  stride_q [MAX_DIMS];
  logic [DIG_W-1:0]  da_q;
  logic signed [AW-1:0] acc_q;
  logic signed [63:0]   prod_q;

  logic              out_valid_q;
  logic [IDX_W-1:0]  out_col_q;
  logic [VAL_W-1:0]  out_val_q;
  logic              out_last_q, out_err_q;
  logic              out_free;
  logic              out_load;

  logic              in_acc;
  act_e              act;
  tbl_wr_t           wr;

  logic              div_start, div_done;
  logic [IDX_W-1:0]  div_quot;
  logic [GRID_W-1:0] div_rem;

  logic [2:0]        e_first, e_second;
  logic [VAL_W-1:0]  e_weight, pot_rd;
  logic [7:0]        pot_raddr;

  logic [DW-1:0]     dsel;
  logic [DIG_W-1:0]  dig_rd;
  logic [IDX_W-1:0]  stride_rd;

  logic [56:0]       tot_prod;
  logic [7:0]        nd30;
  logic signed [40:0] fnd;
  logic [DIG_W-1:0]  db;
  logic [GRID_W:0]   dsum;
  logic [GRID_W:0]   diff;
  logic signed [63:0] rnd;
  logic [VAL_W-1:0]  diag_sat, f16_sat, fneg_sat;
  logic signed [35:0] f16;
  logic signed [32:0] fneg;
  logic signed [10:0] kval, nv0, nv, delta;
  logic signed [59:0] colmul;
  logic              last_nb;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q  <= 9'd5;
      dims_q  <= 4'd1;
      edges_q <= '0;
      fact_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_GRID:  grid_q  <= cfg_wdata_i[GRID_W-1:0];
        REG_DIMS:  dims_q  <= cfg_wdata_i[3:0];
        REG_EDGES: edges_q <= cfg_wdata_i[5:0];
        REG_FACT:  fact_q  <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  always_comb begin
    g_eff = grid_q;
    if (grid_q < 9'd5) g_eff = 9'd5;
    if (grid_q > 9'(MAX_GRID)) g_eff = 9'(MAX_GRID);
    nd_eff = dims_q;
    if (dims_q == 4'd0) nd_eff = 4'd1;
    if (dims_q > 4'(MAX_DIMS)) nd_eff = 4'(MAX_DIMS);
    ne_c = ECW'(edges_q);
    if (7'(edges_q) > 7'(MAX_EDGES)) ne_c = ECW'(MAX_EDGES);
    nd_c = CW'(nd_eff);
  end

  // ---------------- input side ----------------
  assign act           = act_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign wr.edge_we = in_acc && (act == ACT_EDGE);
  assign wr.pot_we  = in_acc && (act == ACT_POT);
  assign wr.addr    = s_axis_tdata[55:48];
  assign wr.first   = s_axis_tdata[58:56];
  assign wr.second  = s_axis_tdata[61:59];
  assign wr.word    = s_axis_tdata[93:62];

  psrg_tables #(
    .MAX_EDGES(MAX_EDGES)
  ) u_tables (
    .clk_i         (clk_i),
    .wr_i          (wr),
    .edge_raddr_i  (ecnt_q[EW-1:0]),
    .pot_raddr_i   (pot_raddr),
    .edge_first_o  (e_first),
    .edge_second_o (e_second),
    .edge_weight_o (e_weight),
    .pot_o         (pot_rd)
  );

  assign div_start = (state_q == S_DIV_START);

  psrg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (g_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ---------------- datapath ----------------
  always_comb begin
    if (state_q == S_EDGE_DA) begin
      dsel = DW'(e_first);
    end else if (state_q == S_EDGE_DB) begin
      dsel = DW'(e_second);
    end else begin
      dsel = dcnt_q[DW-1:0];
    end
  end
  assign dig_rd    = digit_q[dsel];
  assign stride_rd = stride_q[dsel];

  assign tot_prod = total_q * g_eff;
  assign nd30     = 8'(nd_eff) * 8'd30;
  assign fnd      = $signed(fact_q) * $signed({1'b0, nd30});

  assign db        = (4'(e_second) < nd_eff) ? dig_rd : '0;
  assign dsum      = 10'(da_q) + 10'(g_eff) - 10'(db);
  assign diff      = (dsum >= 10'(g_eff)) ? dsum - 10'(g_eff) : dsum;
  assign pot_raddr = diff[7:0];

  assign rnd = (prod_q + 64'sd32768) >>> 16;

  always_comb begin
    diag_sat = acc_q[VAL_W-1:0];
    if (acc_q > AW'(64'sd2147483647)) diag_sat = 32'h7fffffff;
    if (acc_q < -AW'(64'sd2147483648)) diag_sat = 32'h80000000;
    f16  = $signed({fact_q, 4'b0000});
    fneg = -$signed({fact_q[VAL_W-1], fact_q});
    f16_sat = f16[VAL_W-1:0];
    if (f16 > 36'sd2147483647) f16_sat = 32'h7fffffff;
    if (f16 < -36'sd2147483648) f16_sat = 32'h80000000;
    fneg_sat = fneg[VAL_W-1:0];
    if (fneg > 33'sd2147483647) fneg_sat = 32'h7fffffff;
  end

  always_comb begin
    case (oi_q)
      2'd0:    kval = -11'sd2;
      2'd1:    kval = -11'sd1;
      2'd2:    kval = 11'sd1;
      default: kval = 11'sd2;
    endcase
    nv0 = $signed({3'b000, dig_rd}) + kval;
    nv  = nv0;
    if (nv0 < 11'sd0) begin
      nv = nv0 + $signed({2'b00, g_eff});
    end else if (nv0 >= $signed({2'b00, g_eff})) begin
      nv = nv0 - $signed({2'b00, g_eff});
    end
    delta  = nv - $signed({3'b000, dig_rd});
    colmul = delta * $signed({1'b0, stride_rd});
  end

  assign last_nb  = (oi_q == 2'd3) && (dcnt_q == nd_c - CW'(1));
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = out_free && (state_q == S_EMIT_DIAG || state_q == S_EMIT_NB);

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && act == ACT_GEN) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (dcnt_q == nd_c) begin
          state_d = (!big_q && row_q >= total_q) ? S_EMIT_DIAG : S_DIV_START;
        end
      end
      S_DIV_START: state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          if (dcnt_q + CW'(1) != nd_c) begin
            state_d = S_DIV_START;
          end else if (ne_c == '0) begin
            state_d = S_EMIT_DIAG;
          end else begin
            state_d = S_EDGE_RD;
          end
        end
      end
      S_EDGE_RD:  state_d = S_EDGE_DA;
      S_EDGE_DA:  state_d = S_EDGE_DB;
      S_EDGE_DB:  state_d = S_EDGE_MUL;
      S_EDGE_MUL: state_d = S_EDGE_ACC;
      S_EDGE_ACC: begin
        state_d = (ecnt_q + ECW'(1) == ne_c) ? S_EMIT_DIAG : S_EDGE_RD;
      end
      S_EMIT_DIAG: begin
        if (out_free) state_d = err_q ? S_IDLE : S_EMIT_NB;
      end
      S_EMIT_NB: begin
        if (out_free && last_nb) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      ecnt_q      <= '0;
      oi_q        <= '0;
      big_q       <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      // load a new word or drop the one just taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          dcnt_q <= '0;
          ecnt_q <= '0;
          oi_q   <= '0;
          big_q  <= 1'b0;
          err_q  <= 1'b0;
        end
        S_CHECK: begin
          if (dcnt_q == nd_c) begin
            dcnt_q <= '0;
            err_q  <= !big_q && row_q >= total_q;
          end else begin
            dcnt_q <= dcnt_q + CW'(1);
            big_q  <= big_q | (|tot_prod[56:IDX_W]);
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            dcnt_q <= (dcnt_q + CW'(1) == nd_c) ? '0 : dcnt_q + CW'(1);
          end
        end
        S_EDGE_ACC: ecnt_q <= ecnt_q + ECW'(1);
        S_EMIT_NB: begin
          if (out_free) begin
            if (dcnt_q == nd_c - CW'(1)) begin
              dcnt_q <= '0;
              oi_q   <= oi_q + 2'd1;
            end else begin
              dcnt_q <= dcnt_q + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        row_q   <= s_axis_tdata[IDX_W-1:0];
        rem_q   <= s_axis_tdata[IDX_W-1:0];
        total_q <= IDX_W'(1);
        acc_q   <= -AW'(fnd);
      end
      S_CHECK: begin
        if (dcnt_q != nd_c) begin
          stride_q[dcnt_q[DW-1:0]] <= total_q;
          total_q <= tot_prod[IDX_W-1:0];
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          digit_q[dcnt_q[DW-1:0]] <= div_rem[DIG_W-1:0];
          rem_q <= div_quot;
        end
      end
      S_EDGE_DA:  da_q   <= (4'(e_first) < nd_eff) ? dig_rd : '0;
      S_EDGE_MUL: prod_q <= $signed(e_weight) * $signed(pot_rd);
      S_EDGE_ACC: acc_q  <= acc_q + AW'(rnd);
      S_EMIT_DIAG: begin
        if (out_free) begin
          out_col_q  <= err_q ? '0 : row_q;
          out_val_q  <= err_q ? '0 : diag_sat;
          out_last_q <= err_q;
          out_err_q  <= err_q;
        end
      end
      S_EMIT_NB: begin
        if (out_free) begin
          out_col_q  <= row_q + colmul[IDX_W-1:0];
          out_val_q  <= (oi_q == 2'd1 || oi_q == 2'd2) ? f16_sat : fneg_sat;
          out_last_q <= last_nb;
          out_err_q  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_val_q, out_col_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_err_q;

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error word without last");

  a_gen_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_GEN |=> !s_axis_tready)
    else $error("generate word accepted but block stayed ready");
`endif

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the periodic stencil row generator. Loads the edge
// and potential tables, then walks several grid/dimension/edge/factor
// settings (clamped extremes included) with directed and random rows, table
// writes and dropped words. A scoreboard predicts every row entry and checks
// the output stream word by word under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import psrg_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 50;

  typedef struct {
    logic [47:0] col;
    logic [31:0] val;
    logic        last;
    logic        err;
  } row_entry_t;

  class row_scoreboard;
    row_entry_t  pending_q[$];
    int          errors;
    int          rows_seen;
    int          entries_seen;
    int          error_rows;
    logic [8:0]  grid_reg;
    logic [3:0]  dims_reg;
    logic [5:0]  edges_reg;
    logic [31:0] fact_reg;
    logic [2:0]  edge_a[32];
    logic [2:0]  edge_b[32];
    int          edge_w[32];
    int          pot[256];

    function new();
      grid_reg  = 9'd5;
      dims_reg  = 4'd1;
      edges_reg = 6'd0;
      fact_reg  = 32'd0;
    endfunction

    function void set_reg(reg_e idx, logic [31:0] value);
      case (idx)
        REG_GRID:  grid_reg  = value[8:0];
        REG_DIMS:  dims_reg  = value[3:0];
        REG_EDGES: edges_reg = value[5:0];
        default:   fact_reg  = value;
      endcase
    endfunction

    function logic [31:0] sat32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
    endfunction

    function int grid_eff();
      return (grid_reg < 5) ? 5 : (grid_reg > 256) ? 256 : int'(grid_reg);
    endfunction

    function int dims_eff();
      return (dims_reg < 1) ? 1 : (dims_reg > 8) ? 8 : int'(dims_reg);
    endfunction

    // returns 0 when the grid has more rows than 64 bits can count
    function longint unsigned row_count();
      longint unsigned tot;
      int g;
      g = grid_eff();
      tot = 1;
      for (int d = 0; d < dims_eff(); d++) begin
        if (tot > 64'hFFFF_FFFF_FFFF_FFFF / g) return 0;
        tot = tot * g;
      end
      return tot;
    endfunction

    function void predict_row(logic [47:0] row);
      int              g, nd, ne, da, db, nv;
      int              digit[9];
      longint unsigned stride[9];
      longint unsigned rem, s, tot, col;
      longint          fact, diag, prod;
      logic [31:0]     val;
      row_entry_t      en;
      int              cnt;
      g = grid_eff();
      nd = dims_eff();
      ne = (edges_reg > 32) ? 32 : int'(edges_reg);
      tot = row_count();
      rows_seen++;
      if (tot != 0 && {16'd0, row} >= tot) begin
        en = '{col: '0, val: '0, last: 1'b1, err: 1'b1};
        pending_q.push_back(en);
        error_rows++;
        return;
      end
      rem = row;
      s = 1;
      for (int d = 0; d < 9; d++) begin
        digit[d] = 0;
        stride[d] = 0;
      end
      for (int d = 0; d < nd; d++) begin
        digit[d] = int'(rem % g);
        rem = rem / g;
        stride[d] = s;
        s = s * g;
      end
      fact = longint'($signed(fact_reg));
      diag = fact * (-30 * nd);
      for (int e = 0; e < ne; e++) begin
        da = (edge_a[e] < nd) ? digit[edge_a[e]] : 0;
        db = (edge_b[e] < nd) ? digit[edge_b[e]] : 0;
        prod = longint'(edge_w[e]) * longint'(pot[(da + g - db) % g]);
        diag = diag + ((prod + 32768) >>> 16);
      end
      en = '{col: row, val: sat32(diag), last: 1'b0, err: 1'b0};
      pending_q.push_back(en);
      cnt = 1;
      for (int k = -2; k <= 2; k++) begin
        if (k == 0) continue;
        val = (k == 1 || k == -1) ? sat32(fact * 16) : sat32(-fact);
        for (int d = 0; d < nd; d++) begin
          nv = digit[d] + k;
          if (nv < 0) nv += g;
          else if (nv >= g) nv -= g;
          col = longint'(row) - longint'(digit[d]) * stride[d] + longint'(nv) * stride[d];
          cnt++;
          en = '{col: col[47:0], val: val, last: (cnt == 1 + 4 * nd), err: 1'b0};
          pending_q.push_back(en);
        end
      end
    endfunction

    function void note_word(act_e act, logic [95:0] data);
      logic [7:0] slot;
      slot = data[55:48];
      case (act)
        ACT_GEN: predict_row(data[47:0]);
        ACT_EDGE: begin
          if (slot < 32) begin
            edge_a[slot] = data[58:56];
            edge_b[slot] = data[61:59];
            edge_w[slot] = $signed(data[93:62]);
          end
        end
        ACT_POT: pot[slot] = $signed(data[93:62]);
        default: ;
      endcase
    endfunction

    function void check_entry(logic [79:0] data, logic last, logic err);
      row_entry_t ex;
      entries_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word col=%h val=%h last=%b err=%b",
                 $time, data[47:0], data[79:48], last, err);
        errors++;
        return;
      end
      ex = pending_q.pop_front();
      if (data[47:0] !== ex.col) begin
        $display("%0t: column mismatch exp=%h act=%h", $time, ex.col, data[47:0]);
        errors++;
      end
      if (data[79:48] !== ex.val) begin
        $display("%0t: value mismatch exp=%h act=%h (col %h)", $time, ex.val,
                 data[79:48], ex.col);
        errors++;
      end
      if (last !== ex.last) begin
        $display("%0t: tlast mismatch exp=%b act=%b", $time, ex.last, last);
        errors++;
      end
      if (err !== ex.err) begin
        $display("%0t: error flag mismatch exp=%b act=%b", $time, ex.err, err);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  row_scoreboard sb = new();
  int            cycles = 0;
  int            burst_left;
  int            stall_mode = 0;
  int            stall_left = 0;

  periodic_stencil_row_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // check accepted words, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_entry(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (cycles % 8) >= 6;
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, sb.pending_q.size());
      $display("periodic_stencil_row_generator regression: fail");
      $finish;
    end
  end

  // send one word; gaps fall between bursts
  task automatic send_word(act_e act, logic [95:0] data);
    s_axis_tdata  <= data;
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(act, data);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [95:0] pack_word(logic [47:0] row, logic [7:0] slot,
                                            logic [2:0] fa, logic [2:0] fb,
                                            logic [31:0] w);
    return {2'b00, w, fb, fa, slot, row};
  endfunction

  task automatic gen_row(logic [47:0] row);
    send_word(ACT_GEN, pack_word(row, 8'($urandom), 3'($urandom), 3'($urandom),
                                 $urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] g, logic [31:0] nd, logic [31:0] ne,
                            logic [31:0] f);
    reg_e        idx [4];
    logic [31:0] vals[4];
    idx  = '{REG_GRID, REG_DIMS, REG_EDGES, REG_FACT};
    vals = '{g, nd, ne, f};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] pick_row();
    longint unsigned tot, r;
    tot = sb.row_count();
    r = {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF;
    case ($urandom_range(0, 19))
      0:       return 48'd0;
      1:       return 48'hFFFF_FFFF_FFFF;
      2, 3:    return (tot != 0 && tot <= 64'hFFFF_FFFF_FFFF) ? tot[47:0] : r[47:0];
      4, 5:    return (tot != 0 && tot <= 64'h1_0000_0000_0000) ? 48'(tot - 1) : r[47:0];
      default: return (tot != 0 && tot <= 64'hFFFF_FFFF_FFFF) ? 48'(r % tot) : r[47:0];
    endcase
  endfunction

  task automatic random_items(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14)
        gen_row(pick_row());
      else if (pick < 17)
        send_word(ACT_EDGE, pack_word(48'({$urandom, $urandom}),
                                      8'($urandom_range(0, 63)),
                                      3'($urandom), 3'($urandom), rand_word()));
      else if (pick < 19)
        send_word(ACT_POT, pack_word(48'({$urandom, $urandom}), 8'($urandom),
                                     3'($urandom), 3'($urandom), rand_word()));
      else
        send_word(ACT_NONE, {$urandom, $urandom, $urandom});
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_GEN;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_GRID;
    cfg_wdata_i   = '0;
    burst_left    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the edge table and the low potential slots; any setting with
    // edges keeps its grid within those slots
    for (int i = 0; i < 32; i++)
      send_word(ACT_POT, pack_word(48'({$urandom, $urandom}), 8'(i), 3'($urandom),
                                   3'($urandom), rand_word()));
    for (int i = 0; i < 32; i++)
      send_word(ACT_EDGE, pack_word(48'({$urandom, $urandom}), 8'(i), 3'($urandom),
                                    3'($urandom), rand_word()));

    // directed: reset settings, error rows, ignored words, saturating edge
    gen_row(48'd0);
    gen_row(48'd4);
    gen_row(48'd5);
    gen_row(48'hFFFF_FFFF_FFFF);
    send_word(ACT_EDGE, pack_word(48'd0, 8'd32, 3'd7, 3'd7, 32'h7FFF_FFFF));
    send_word(ACT_EDGE, pack_word(48'd0, 8'd255, 3'd0, 3'd0, 32'h7FFF_FFFF));
    send_word(ACT_NONE, {96{1'b1}});
    send_word(ACT_EDGE, pack_word(48'd0, 8'd0, 3'd0, 3'd7, 32'h8000_0000));
    send_word(ACT_POT, pack_word(48'd0, 8'd0, 3'd0, 3'd0, 32'h8000_0000));
    send_word(ACT_POT, pack_word(48'd0, 8'd255, 3'd7, 3'd7, 32'h7FFF_FFFF));
    write_regs(32'd7, 32'd3, 32'd4, 32'h0001_0000);
    gen_row(48'd0);
    gen_row(48'd342);
    gen_row(48'd343);
    gen_row(48'd171);
    random_items(25);

    // out-of-range register values clamp to the nearest legal setting
    write_regs(32'd0, 32'd0, 32'd63, 32'h7FFF_FFFF);
    gen_row(48'd0);
    gen_row(48'd4);
    gen_row(48'd5);
    random_items(20);
    write_regs(32'd511, 32'd15, 32'd0, 32'h8000_0000);
    gen_row(48'd0);
    gen_row(48'hFFFF_FFFF_FFFF);
    random_items(8);
    write_regs(32'd256, 32'd6, 32'd0, $urandom);
    random_items(12);
    write_regs(32'd13, 32'd4, 32'd17, rand_word());
    random_items(15);
    drain();
    random_items(15);
    write_regs(32'd32, 32'd8, 32'd5, rand_word());
    random_items(12);
    write_regs(32'd200, 32'd7, 32'd0, rand_word());
    random_items(12);
    write_regs(32'd5, 32'd2, 32'd2, 32'hFFFF_FFFF);
    random_items(15);
    write_regs(32'd9, 32'd5, 32'd31, rand_word());
    random_items(15);

    drain();
    $display("rows: %0d (%0d out of grid), words checked: %0d, mismatches: %0d",
             sb.rows_seen, sb.error_rows, sb.entries_seen, sb.errors);
    $display("settings covered: clamped and extreme grid, dims, edges, factor");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("periodic_stencil_row_generator regression: pass");
    end else begin
      $display("periodic_stencil_row_generator regression: fail");
    end
    $finish;
  end
endmodule
